[src/lemc_pkg.sv]
// Package: event and result types, codes and constants of the LED effect controller.
package lemc_pkg;

  localparam int unsigned LED_COUNT = 8;

  localparam logic [7:0]  SPEED_INIT = 8'(64 - 1);
  localparam int unsigned GAUGE_STEP = 512;
  localparam logic [11:0] GAUGE_TOP  = 12'(4096 - 30);
  localparam logic [7:0]  DOT_TOP    = 8'h80;
  localparam logic [7:0]  DOT_BOTTOM = 8'h01;
  localparam logic [15:0] SNAKE_SEED = 16'h00ff;
  localparam logic [7:0]  ALL_ON     = 8'hff;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_MODE   = 2'd1,
    KIND_COLOUR = 2'd2,
    KIND_STEP   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    MODE_COUNT  = 3'd0,
    MODE_GAUGE  = 3'd1,
    MODE_BOUNCE = 3'd2,
    MODE_SNAKE  = 3'd3,
    MODE_BLINK  = 3'd4,
    MODE_COLOUR = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    SEL_RED   = 2'd0,
    SEL_GREEN = 2'd1,
    SEL_BLUE  = 2'd2,
    SEL_MIXED = 2'd3
  } sel_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  colour_choice;
    logic        step_up;
    logic [11:0] gauge_sample;
  } lemc_in_t;

  typedef struct packed {
    logic [7:0] led_bar;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic       colour_active;
    logic [2:0] current_mode;
    logic [1:0] colour_selected;
  } lemc_out_t;

endpackage

[src/lemc_engine.sv]
// Effect engine: mode, colour, speed and pattern state with its per-event update.
module lemc_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  lemc_pkg::lemc_in_t  item_i,
  output lemc_pkg::lemc_out_t result_o
);
  import lemc_pkg::*;

  mode_e      mode_q, mode_d;
  sel_e       sel_q, sel_d;
  logic [7:0] speed_q, speed_d;
  logic [7:0] red_q, red_d;
  logic [7:0] green_q, green_d;
  logic [7:0] blue_q, blue_d;
  logic [7:0] pattern_q, pattern_d;
  logic [2:0] bounce_pos_q, bounce_pos_d;
  logic       bounce_down_q, bounce_down_d;
  logic [8:0] bounce_tmr_q, bounce_tmr_d;
  logic [3:0] snake_pos_q, snake_pos_d;
  logic [8:0] snake_tmr_q, snake_tmr_d;
  logic [8:0] blink_tmr_q, blink_tmr_d;

  logic [8:0]  bounce_tmr_inc, snake_tmr_inc, blink_tmr_inc;
  logic        bounce_exp, snake_exp, blink_exp;
  logic [7:0]  dot;
  logic        dir_down;
  logic [15:0] snake_shift;
  logic        active;

  function automatic logic [7:0] gauge_bar(input logic [11:0] sample);
    logic [7:0]  bar;
    logic [11:0] thr;
    bar = '0;
    for (int unsigned i = 0; i < LED_COUNT; i++) begin
      thr = (i == LED_COUNT - 1) ? GAUGE_TOP : 12'(GAUGE_STEP * (i + 1));
      bar[i] = (sample > thr);
    end
    return bar;
  endfunction

  function automatic logic [7:0] sel_level(input sel_e sel, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b);
    logic [7:0] lvl;
    unique case (sel)
      SEL_RED:   lvl = r;
      SEL_GREEN: lvl = g;
      SEL_BLUE:  lvl = b;
      default:   lvl = '0;
    endcase
    return lvl;
  endfunction

  // Pacing timers: expire once the count passes the speed value.
  assign bounce_tmr_inc = bounce_tmr_q + 9'd1;
  assign snake_tmr_inc  = snake_tmr_q + 9'd1;
  assign blink_tmr_inc  = blink_tmr_q + 9'd1;
  assign bounce_exp     = bounce_tmr_inc > {1'b0, speed_q};
  assign snake_exp      = snake_tmr_inc > {1'b0, speed_q};
  assign blink_exp      = blink_tmr_inc > {1'b0, speed_q};

  assign dot = 8'd1 << bounce_pos_q;
  always_comb begin
    dir_down = bounce_down_q;
    if (dot == DOT_TOP) dir_down = 1'b1;
    if (dot == DOT_BOTTOM) dir_down = 1'b0;
  end

  assign snake_shift = SNAKE_SEED << snake_pos_q;

  always_comb begin
    mode_d        = mode_q;
    sel_d         = sel_q;
    speed_d       = speed_q;
    red_d         = red_q;
    green_d       = green_q;
    blue_d        = blue_q;
    pattern_d     = pattern_q;
    bounce_pos_d  = bounce_pos_q;
    bounce_down_d = bounce_down_q;
    bounce_tmr_d  = bounce_tmr_q;
    snake_pos_d   = snake_pos_q;
    snake_tmr_d   = snake_tmr_q;
    blink_tmr_d   = blink_tmr_q;
    active        = 1'b0;

    unique case (item_i.kind)
      KIND_TICK: begin
        active = (mode_q == MODE_COLOUR);
        unique case (mode_q)
          MODE_COUNT: pattern_d = speed_q;
          MODE_GAUGE: pattern_d = gauge_bar(item_i.gauge_sample);
          MODE_BOUNCE: begin
            bounce_tmr_d = bounce_exp ? 9'd0 : bounce_tmr_inc;
            if (bounce_exp) begin
              pattern_d     = dot;
              bounce_down_d = dir_down;
              bounce_pos_d  = dir_down ? bounce_pos_q - 3'd1 : bounce_pos_q + 3'd1;
            end
          end
          MODE_SNAKE: begin
            snake_tmr_d = snake_exp ? 9'd0 : snake_tmr_inc;
            if (snake_exp) begin
              pattern_d   = snake_shift[15:8];
              snake_pos_d = snake_pos_q + 4'd1;
            end
          end
          MODE_BLINK: begin
            blink_tmr_d = blink_exp ? 9'd0 : blink_tmr_inc;
            if (blink_exp) pattern_d = pattern_q ^ ALL_ON;
          end
          MODE_COLOUR: pattern_d = sel_level(sel_q, red_q, green_q, blue_q);
          default: ;
        endcase
      end
      KIND_MODE: begin
        mode_d = (mode_q >= MODE_COLOUR) ? MODE_COUNT : mode_e'(mode_q + 3'd1);
      end
      KIND_COLOUR: begin
        // choice three is not a button
        if (item_i.colour_choice != SEL_MIXED) begin
          sel_d = (sel_q == sel_e'(item_i.colour_choice)) ? SEL_MIXED
                                                           : sel_e'(item_i.colour_choice);
        end
      end
      KIND_STEP: begin
        if (mode_q == MODE_COLOUR) begin
          unique case (sel_q)
            SEL_RED:   red_d   = item_i.step_up ? red_q + 8'd1 : red_q - 8'd1;
            SEL_GREEN: green_d = item_i.step_up ? green_q + 8'd1 : green_q - 8'd1;
            SEL_BLUE:  blue_d  = item_i.step_up ? blue_q + 8'd1 : blue_q - 8'd1;
            default: ;
          endcase
        end else if (item_i.step_up) begin
          if (speed_q != ALL_ON) speed_d = speed_q + 8'd1;
        end else begin
          if (speed_q != 8'd0) speed_d = speed_q - 8'd1;
        end
      end
    endcase
  end

  always_comb begin
    result_o.led_bar         = pattern_d;
    result_o.red_level       = (active && (sel_d == SEL_RED || sel_d == SEL_MIXED))
                               ? red_d : 8'd0;
    result_o.green_level     = (active && (sel_d == SEL_GREEN || sel_d == SEL_MIXED))
                               ? green_d : 8'd0;
    result_o.blue_level      = (active && (sel_d == SEL_BLUE || sel_d == SEL_MIXED))
                               ? blue_d : 8'd0;
    result_o.colour_active   = active;
    result_o.current_mode    = mode_d;
    result_o.colour_selected = sel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_BOUNCE;
      sel_q         <= SEL_GREEN;
      speed_q       <= SPEED_INIT;
      red_q         <= SPEED_INIT;
      green_q       <= SPEED_INIT;
      blue_q        <= SPEED_INIT;
      pattern_q     <= '0;
      bounce_pos_q  <= '0;
      bounce_down_q <= 1'b0;
      bounce_tmr_q  <= '0;
      snake_pos_q   <= '0;
      snake_tmr_q   <= '0;
      blink_tmr_q   <= '0;
    end else if (step_i) begin
      mode_q        <= mode_d;
      sel_q         <= sel_d;
      speed_q       <= speed_d;
      red_q         <= red_d;
      green_q       <= green_d;
      blue_q        <= blue_d;
      pattern_q     <= pattern_d;
      bounce_pos_q  <= bounce_pos_d;
      bounce_down_q <= bounce_down_d;
      bounce_tmr_q  <= bounce_tmr_d;
      snake_pos_q   <= snake_pos_d;
      snake_tmr_q   <= snake_tmr_d;
      blink_tmr_q   <= blink_tmr_d;
    end
  end

endmodule

[src/led_effect_mode_controller.sv]
// Top level: request register, effect engine and result register of the LED controller.
//
// Takes one event request per clock (tick, mode button, colour button or
// encoder step) and returns one result per request showing the LEDs, colour
// levels, mode and colour selection after that event. Sustained rate is one
// request per cycle while results are taken; the request register and then
// the result register hold it, with the state update done between them in a
// single pass. Output backpressure stalls the request register, so input
// ready drops only when both registers are full and the result is not taken.
module led_effect_mode_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lemc_pkg::lemc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lemc_pkg::lemc_out_t out_data_o
);
  import lemc_pkg::*;

  lemc_in_t  item_q;
  logic      item_vld_q;
  lemc_out_t res_q, res_d;
  logic      res_vld_q;
  logic      advance;

  assign advance    = item_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !item_vld_q || advance;

  lemc_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (item_q),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_ready_o) item_vld_q <= in_valid_i;
      if (advance) begin
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) item_q <= in_data_i;
    if (advance) res_q <= res_d;
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

  a_advance_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_vld_q)
    else $error("processed request did not reach the result register");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (item_vld_q && res_vld_q && !out_ready_i))
    else $error("input stalled while a register had room");

  a_active_in_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.colour_active) |-> (out_data_o.current_mode == MODE_COLOUR))
    else $error("colour LED active outside colour mode");

  a_levels_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.colour_active) |->
      (out_data_o.red_level == 8'd0 && out_data_o.green_level == 8'd0 &&
       out_data_o.blue_level == 8'd0))
    else $error("colour levels nonzero while colour LED inactive");

endmodule

[bench/tb_led_effect_mode_controller.sv]
// Testbench for the LED effect controller: random and directed event requests, scoreboard check.
module tb_led_effect_mode_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import lemc_pkg::*;

  // Tracks the controller state and holds the expected result for each accepted request.
  class lemc_scoreboard;
    mode_e      mode;
    sel_e       sel;
    logic [7:0] speed, red, green, blue, pattern;
    logic [2:0] dot_pos;
    logic       dot_down;
    logic [8:0] dot_timer, snake_timer, blink_timer;
    logic [3:0] snake_pos;
    lemc_out_t  expected_q[$];
    int unsigned errors;

    function new();
      mode        = MODE_BOUNCE;
      sel         = SEL_GREEN;
      speed       = SPEED_INIT;
      red         = SPEED_INIT;
      green       = SPEED_INIT;
      blue        = SPEED_INIT;
      pattern     = '0;
      dot_pos     = '0;
      dot_down    = 1'b0;
      dot_timer   = '0;
      snake_timer = '0;
      blink_timer = '0;
      snake_pos   = '0;
      errors      = 0;
    endfunction

    // Pacing timer: true when it passes the speed value, and then it restarts.
    function bit advance(input logic [8:0] t, output logic [8:0] t_next);
      t_next = t + 9'd1;
      if (t_next > {1'b0, speed}) begin
        t_next = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic [7:0] gauge_leds(logic [11:0] sample);
      logic [7:0] bar;
      for (int i = 0; i < LED_COUNT - 1; i++) bar[i] = sample > GAUGE_STEP * (i + 1);
      bar[LED_COUNT-1] = sample > GAUGE_TOP;
      return bar;
    endfunction

    function logic [7:0] sel_level();
      case (sel)
        SEL_RED:   return red;
        SEL_GREEN: return green;
        SEL_BLUE:  return blue;
        default:   return '0;
      endcase
    endfunction

    function void note_request(lemc_in_t req);
      lemc_out_t   exp;
      logic [15:0] snake_bits;
      bit          active;
      active = 1'b0;
      case (kind_e'(req.kind))
        KIND_TICK: begin
          case (mode)
            MODE_COUNT: pattern = speed;
            MODE_GAUGE: pattern = gauge_leds(req.gauge_sample);
            MODE_BOUNCE: begin
              if (advance(dot_timer, dot_timer)) begin
                pattern = 8'd1 << dot_pos;
                if (pattern == DOT_TOP) dot_down = 1'b1;
                if (pattern == DOT_BOTTOM) dot_down = 1'b0;
                dot_pos = dot_down ? dot_pos - 3'd1 : dot_pos + 3'd1;
              end
            end
            MODE_SNAKE: begin
              if (advance(snake_timer, snake_timer)) begin
                snake_bits = SNAKE_SEED << snake_pos;
                pattern = snake_bits[15:8];
                snake_pos = snake_pos + 4'd1;
              end
            end
            MODE_BLINK: begin
              if (advance(blink_timer, blink_timer)) pattern = pattern ^ ALL_ON;
            end
            MODE_COLOUR: pattern = sel_level();
            default: ;
          endcase
          active = (mode == MODE_COLOUR);
        end
        KIND_MODE: mode = (mode >= MODE_COLOUR) ? MODE_COUNT : mode_e'(mode + 3'd1);
        KIND_COLOUR: begin
          if (sel_e'(req.colour_choice) != SEL_MIXED)
            sel = (sel == sel_e'(req.colour_choice)) ? SEL_MIXED : sel_e'(req.colour_choice);
        end
        default: begin
          if (mode == MODE_COLOUR) begin
            case (sel)
              SEL_RED:   red   = req.step_up ? red + 8'd1 : red - 8'd1;
              SEL_GREEN: green = req.step_up ? green + 8'd1 : green - 8'd1;
              SEL_BLUE:  blue  = req.step_up ? blue + 8'd1 : blue - 8'd1;
              default: ;
            endcase
          end else if (req.step_up) begin
            if (speed != ALL_ON) speed = speed + 8'd1;
          end else if (speed != 8'd0) begin
            speed = speed - 8'd1;
          end
        end
      endcase
      exp.led_bar         = pattern;
      exp.red_level       = (active && (sel == SEL_RED   || sel == SEL_MIXED)) ? red   : '0;
      exp.green_level     = (active && (sel == SEL_GREEN || sel == SEL_MIXED)) ? green : '0;
      exp.blue_level      = (active && (sel == SEL_BLUE  || sel == SEL_MIXED)) ? blue  : '0;
      exp.colour_active   = active;
      exp.current_mode    = mode;
      exp.colour_selected = sel;
      expected_q.push_back(exp);
    endfunction

    function void check_result(lemc_out_t got);
      lemc_out_t exp;
      bit        bad;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result with no request pending", $realtime);
        return;
      end
      exp = expected_q.pop_front();
      bad = (got.led_bar != exp.led_bar) || (got.red_level != exp.red_level) ||
            (got.green_level != exp.green_level) || (got.blue_level != exp.blue_level) ||
            (got.colour_active != exp.colour_active) ||
            (got.current_mode != exp.current_mode) ||
            (got.colour_selected != exp.colour_selected);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch exp led=%h r=%h g=%h b=%h act=%b mode=%0d sel=%0d",
                   $realtime, exp.led_bar, exp.red_level, exp.green_level, exp.blue_level,
                   exp.colour_active, exp.current_mode, exp.colour_selected);
          $display("%0t:          got led=%h r=%h g=%h b=%h act=%b mode=%0d sel=%0d",
                   $realtime, got.led_bar, got.red_level, got.green_level, got.blue_level,
                   got.colour_active, got.current_mode, got.colour_selected);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  lemc_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  lemc_out_t out_data;

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;

  lemc_scoreboard sb = new();

  led_effect_mode_controller u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  function automatic lemc_in_t make_req(kind_e k, logic [1:0] choice, logic up,
                                        logic [11:0] sample);
    lemc_in_t req;
    req.kind          = k;
    req.colour_choice = choice;
    req.step_up       = up;
    req.gauge_sample  = sample;
    return req;
  endfunction

  function automatic lemc_in_t rand_req(kind_e k);
    return make_req(k, 2'($urandom_range(3)), 1'($urandom_range(1)),
                    12'($urandom_range(4095)));
  endfunction

  task automatic send_request(lemc_in_t req);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic run_directed();
    send_request(make_req(KIND_TICK, 2'd0, 1'b0, 12'd0));
    send_request(make_req(KIND_MODE, 2'd0, 1'b0, 12'd0));
    send_request(make_req(KIND_MODE, 2'd0, 1'b0, 12'd0));
    send_request(make_req(KIND_MODE, 2'd0, 1'b0, 12'd0));
    send_request(make_req(KIND_TICK, 2'd0, 1'b0, 12'hfff));
    send_request(make_req(KIND_COLOUR, SEL_GREEN, 1'b0, 12'd0));   // same colour again: mixed
    send_request(make_req(KIND_TICK, 2'd0, 1'b0, 12'd0));
    send_request(make_req(KIND_STEP, 2'd0, 1'b1, 12'd0));          // mixed: no level moves
    send_request(make_req(KIND_COLOUR, SEL_MIXED, 1'b1, 12'hfff));  // choice three ignored
    send_request(make_req(KIND_COLOUR, SEL_RED, 1'b0, 12'd0));
    send_request(make_req(KIND_STEP, 2'd0, 1'b0, 12'd0));
    send_request(make_req(KIND_TICK, 2'd0, 1'b0, 12'd0));
    send_request(make_req(KIND_MODE, 2'd0, 1'b0, 12'd0));
    send_request(make_req(KIND_STEP, 2'd0, 1'b1, 12'd0));
    send_request(make_req(KIND_TICK, 2'd0, 1'b0, 12'd0));
    send_request(make_req(KIND_MODE, 2'd0, 1'b0, 12'd0));
    send_request(make_req(KIND_TICK, 2'd0, 1'b0, 12'd0));
    send_request(make_req(KIND_TICK, 2'd0, 1'b0, 12'd512));
    send_request(make_req(KIND_TICK, 2'd0, 1'b0, 12'd513));
    send_request(make_req(KIND_TICK, 2'd0, 1'b0, 12'd4066));
    send_request(make_req(KIND_TICK, 2'd0, 1'b0, 12'd4067));
    send_request(make_req(KIND_TICK, 2'd0, 1'b0, 12'd4095));
    send_request(make_req(KIND_COLOUR, SEL_BLUE, 1'b0, 12'd0));
    send_request(make_req(KIND_MODE, 2'd0, 1'b0, 12'd0));
    send_request(make_req(KIND_TICK, 2'd0, 1'b0, 12'd0));
  endtask

  // Bursts of one event kind; encoder bursts keep one direction so that speed
  // saturates and colour levels wrap, with a downward bias to keep effects fast.
  task automatic run_random(int unsigned n);
    int unsigned sent, r, len;
    lemc_in_t    req;
    logic        dir;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      dir = ($urandom_range(99) >= 55);
      if (r < 45) len = $urandom_range(30, 1);
      else if (r < 65) len = $urandom_range(70, 1);
      else len = $urandom_range(2, 1);
      repeat (len) begin
        if (r < 45) req = rand_req(KIND_TICK);
        else if (r < 65) begin
          req = rand_req(KIND_STEP);
          req.step_up = dir;
        end else if (r < 80) req = rand_req(KIND_MODE);
        else req = rand_req(KIND_COLOUR);
        send_request(req);
        if (!(req.kind == KIND_COLOUR && sel_e'(req.colour_choice) == SEL_MIXED)) sent++;
      end
    end
  endtask

  initial begin
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    idle_tab  = '{0, 72, 0, 10};
    stall_tab = '{0, 0, 72, 10};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < 4; p++) begin
      in_idle_pct   = idle_tab[p];
      out_stall_pct = stall_tab[p];
      run_random(438);
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
